@@ hw/rtl/pfsb_pkg.sv @@
// ----------------------------------------------------------------------------
// pfsb_pkg
// Shared constants, codes and controller/datapath types for the page-mode
// frame store blitter.
// ----------------------------------------------------------------------------
package pfsb_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int SPRITE_SIZE   = 24;

    localparam int PAGES       = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE_BYTES = SCREEN_WIDTH * PAGES;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int COL_W       = $clog2(SCREEN_WIDTH);
    localparam int PG_W        = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int ROW_W       = PG_W + 3;
    localparam int CRD_W       = 11;
    localparam int ROW_BITS_W  = 24;

    typedef enum logic [2:0] {
        ACT_CLEAR  = 3'd0,
        ACT_PIXEL  = 3'd1,
        ACT_RECT   = 3'd2,
        ACT_SPRITE = 3'd3,
        ACT_READ   = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        BLIT_NORMAL = 2'd0,
        BLIT_ROT_CW = 2'd1,
        BLIT_SCALED = 2'd2
    } t_blit_mode;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_SETUP,
        ST_WALK,
        ST_READ
    } t_state;

    typedef struct packed {
        logic load;
        logic setup;
        logic walk;
        logic sweep;
        logic rd;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic last;
        logic sweep_last;
        logic rd_ok;
    } t_dp_status;

endpackage

@@ hw/rtl/page_framebuffer_sprite_blitter.sv @@
// ----------------------------------------------------------------------------
// page_framebuffer_sprite_blitter
// Page-mode 1 bit per pixel frame store with pixel, rectangle, sprite row,
// clear and byte read actions.
// ----------------------------------------------------------------------------
// Input channel: one beat per action (i_valid / o_stall). Output channel: one
// beat per read action only (o_valid / i_stall), carrying the store byte.
// Every drawing action walks the clipped bounding box of its pixels one store
// byte per cycle through a read-modify-write on the single store RAM, so the
// store port sets the rate. A fully clipped action walks no byte. A clear
// sweeps every store byte; a read passes the byte through the store RAM's
// read register and then the result register onto o_read_data.
// After reset the store is cleared by a sweep during which o_stall stays high.
// A result waiting under i_stall does not block drawing actions; a further
// read waits in the block until the result register is empty or being read out.
// ----------------------------------------------------------------------------
module page_framebuffer_sprite_blitter import pfsb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [2:0]            i_action,
    input  logic signed [8:0]     i_x_pos,
    input  logic signed [8:0]     i_y_pos,
    input  logic                  i_pixel_on,
    input  logic [7:0]            i_rect_width,
    input  logic [6:0]            i_rect_height,
    input  logic [ROW_BITS_W-1:0] i_row_bits,
    input  logic [4:0]            i_row_index,
    input  logic [1:0]            i_blit_mode,
    input  logic [9:0]            i_read_address,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [7:0]            o_read_data
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    pfsb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .o_stall  (o_stall),
        .o_cmd    (dp_cmd),
        .i_status (dp_status)
    );

    pfsb_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_status       (dp_status),
        .i_action       (i_action),
        .i_x_pos        (i_x_pos),
        .i_y_pos        (i_y_pos),
        .i_pixel_on     (i_pixel_on),
        .i_rect_width   (i_rect_width),
        .i_rect_height  (i_rect_height),
        .i_row_bits     (i_row_bits),
        .i_row_index    (i_row_index),
        .i_blit_mode    (i_blit_mode),
        .i_read_address (i_read_address),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_read_data    (o_read_data)
    );

endmodule

@@ hw/rtl/pfsb_ram.sv @@
// ----------------------------------------------------------------------------
// pfsb_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module pfsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/pfsb_dp.sv @@
// ----------------------------------------------------------------------------
// pfsb_dp
// Datapath: item registers, bounding box and clipping, byte walk with a
// registered read-modify-write pipeline, clearing sweep and result register.
// ----------------------------------------------------------------------------
module pfsb_dp import pfsb_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_status             o_status,
    input  logic [2:0]             i_action,
    input  logic signed [8:0]      i_x_pos,
    input  logic signed [8:0]      i_y_pos,
    input  logic                   i_pixel_on,
    input  logic [7:0]             i_rect_width,
    input  logic [6:0]             i_rect_height,
    input  logic [ROW_BITS_W-1:0]  i_row_bits,
    input  logic [4:0]             i_row_index,
    input  logic [1:0]             i_blit_mode,
    input  logic [9:0]             i_read_address,
    input  logic                   i_stall,
    output logic                   o_valid,
    output logic [7:0]             o_read_data
);

    localparam logic signed [CRD_W-1:0] C_S1 = CRD_W'(SPRITE_SIZE - 1);
    localparam logic signed [CRD_W-1:0] C_S2 = CRD_W'(2 * SPRITE_SIZE - 1);
    localparam logic signed [CRD_W-1:0] C_W1 = CRD_W'(SCREEN_WIDTH - 1);
    localparam logic signed [CRD_W-1:0] C_H1 = CRD_W'(SCREEN_HEIGHT - 1);

    function automatic logic sprite_bit(input logic [ROW_BITS_W-1:0] bits,
                                        input logic signed [CRD_W-1:0] u);
        logic signed [CRD_W-1:0] idx;
        logic [ROW_BITS_W-1:0]   sh;
        idx = C_S1 - u;
        sh  = bits >> idx;
        return (u >= 0) && (u <= C_S1) && sh[0];
    endfunction

    // item registers
    logic [2:0]            r_act;
    logic signed [8:0]     r_x;
    logic signed [8:0]     r_y;
    logic                  r_on;
    logic [7:0]            r_w;
    logic [6:0]            r_h;
    logic [ROW_BITS_W-1:0] r_bits;
    logic [4:0]            r_ri;
    logic [1:0]            r_mode;
    logic [9:0]            r_addr;

    // walk state
    logic [COL_W-1:0] r_col, r_col_lo, r_col_hi;
    logic [PG_W-1:0]  r_page, r_pg_hi;
    logic [ROW_W-1:0] r_row_lo, r_row_hi;
    logic             r_empty;

    // write pipeline, sweep and result
    logic              r_wr_pend;
    logic              r_wr_set;
    logic [ADDR_W-1:0] r_wr_addr;
    logic [7:0]        r_wr_mask;
    logic [ADDR_W-1:0] r_sweep;
    logic              r_rd_pend;
    logic              r_rd_zero;
    logic              r_out_valid;
    logic [7:0]        r_out_data;

    logic signed [CRD_W-1:0] xs, ys, ri_s, w_s, h_s;
    logic signed [CRD_W-1:0] x0, x1, y0, y1, cx0, cx1, cy0, cy1;
    logic                    none;
    logic                    box_empty;

    logic signed [CRD_W-1:0] col_s, dc, row_s, dr, u;
    logic [ROW_W-1:0]        row_b;
    logic                    solid;
    logic [7:0]              mask;
    logic [ADDR_W-1:0]       walk_addr;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    // bounding box of the item, then clip to the screen
    always_comb begin
        xs   = CRD_W'(r_x);
        ys   = CRD_W'(r_y);
        ri_s = CRD_W'(r_ri);
        w_s  = CRD_W'(r_w);
        h_s  = CRD_W'(r_h);
        x0   = xs;
        x1   = xs;
        y0   = ys;
        y1   = ys;
        none = 1'b1;
        case (r_act)
            ACT_PIXEL: begin
                none = 1'b0;
            end
            ACT_RECT: begin
                x1   = xs + w_s - CRD_W'(1);
                y1   = ys + h_s - CRD_W'(1);
                none = (r_w == '0) || (r_h == '0);
            end
            ACT_SPRITE: begin
                none = (int'(r_ri) >= SPRITE_SIZE);
                case (r_mode)
                    BLIT_NORMAL: begin
                        x1 = xs + C_S1;
                        y0 = ys + ri_s;
                        y1 = ys + ri_s;
                    end
                    BLIT_ROT_CW: begin
                        x0 = xs + C_S1 - ri_s;
                        x1 = xs + C_S1 - ri_s;
                        y1 = ys + C_S1;
                    end
                    BLIT_SCALED: begin
                        x1 = xs + C_S2;
                        y0 = ys + (ri_s <<< 1);
                        y1 = ys + (ri_s <<< 1) + CRD_W'(1);
                    end
                    default: begin
                        none = 1'b1;
                    end
                endcase
            end
            default: begin
                none = 1'b1;
            end
        endcase
        cx0       = (x0 < 0) ? '0 : x0;
        cx1       = (x1 > C_W1) ? C_W1 : x1;
        cy0       = (y0 < 0) ? '0 : y0;
        cy1       = (y1 > C_H1) ? C_H1 : y1;
        box_empty = none || (cx0 > cx1) || (cy0 > cy1);
    end

    // pixel mask of the byte under the walk, one lane per row of the page
    always_comb begin
        col_s = CRD_W'(r_col);
        dc    = col_s - xs;
        solid = (r_act != ACT_SPRITE);
        row_b = '0;
        row_s = '0;
        dr    = '0;
        u     = '0;
        mask  = '0;
        for (int b = 0; b < 8; b++) begin
            row_b = {r_page, 3'(b)};
            row_s = CRD_W'(row_b);
            dr    = row_s - ys;
            if (r_mode == BLIT_ROT_CW) begin
                u = dr;
            end else if (r_mode == BLIT_SCALED) begin
                u = dc >>> 1;
            end else begin
                u = dc;
            end
            mask[b] = (row_b >= r_row_lo) && (row_b <= r_row_hi) &&
                      (solid || sprite_bit(r_bits, u));
        end
        walk_addr = ADDR_W'(r_page) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(r_col);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act  <= i_action;
            r_x    <= i_x_pos;
            r_y    <= i_y_pos;
            r_on   <= i_pixel_on;
            r_w    <= i_rect_width;
            r_h    <= i_rect_height;
            r_bits <= i_row_bits;
            r_ri   <= i_row_index;
            r_mode <= i_blit_mode;
            r_addr <= i_read_address;
        end
        if (i_cmd.setup) begin
            r_empty  <= box_empty;
            r_col    <= cx0[COL_W-1:0];
            r_col_lo <= cx0[COL_W-1:0];
            r_col_hi <= cx1[COL_W-1:0];
            r_page   <= cy0[ROW_W-1:3];
            r_pg_hi  <= cy1[ROW_W-1:3];
            r_row_lo <= cy0[ROW_W-1:0];
            r_row_hi <= cy1[ROW_W-1:0];
        end else if (i_cmd.walk) begin
            if (r_col == r_col_hi) begin
                r_col  <= r_col_lo;
                r_page <= r_page + PG_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
        if (i_cmd.walk) begin
            r_wr_addr <= walk_addr;
            r_wr_mask <= mask;
            r_wr_set  <= solid ? r_on : 1'b1;
        end
        if (i_cmd.rd) begin
            r_rd_zero <= !(int'(r_addr) < STORE_BYTES);
        end
        if (r_rd_pend) begin
            r_out_data <= r_rd_zero ? 8'h00 : ram_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pend   <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
            r_sweep     <= '0;
        end else begin
            r_wr_pend <= i_cmd.walk;
            r_rd_pend <= i_cmd.rd;
            if (r_rd_pend) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.sweep) begin
                r_sweep <= o_status.sweep_last ? '0 : r_sweep + ADDR_W'(1);
            end
        end
    end

    // write back the byte read in the previous cycle, or zero during a sweep
    always_comb begin
        ram_we    = i_cmd.sweep || r_wr_pend;
        ram_waddr = i_cmd.sweep ? r_sweep : r_wr_addr;
        if (i_cmd.sweep) begin
            ram_wdata = 8'h00;
        end else if (r_wr_set) begin
            ram_wdata = ram_rdata | r_wr_mask;
        end else begin
            ram_wdata = ram_rdata & ~r_wr_mask;
        end
        ram_raddr = i_cmd.rd ? ADDR_W'(r_addr) : walk_addr;
    end

    pfsb_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_status.empty      = r_empty;
    assign o_status.last       = (r_col == r_col_hi) && (r_page == r_pg_hi);
    assign o_status.sweep_last = (r_sweep == ADDR_W'(STORE_BYTES - 1));
    assign o_status.rd_ok      = !r_rd_pend && (!r_out_valid || !i_stall);

    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_data;

endmodule

@@ hw/rtl/pfsb_ctrl.sv @@
// ----------------------------------------------------------------------------
// pfsb_ctrl
// Controller: takes input beats, sequences setup, byte walk, clearing sweep
// and store reads through the datapath.
// ----------------------------------------------------------------------------
module pfsb_ctrl import pfsb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [2:0] i_action,
    output logic       o_stall,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            ST_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    unique case (i_action) inside
                        ACT_CLEAR:                        n_state = ST_SWEEP;
                        ACT_PIXEL, ACT_RECT, ACT_SPRITE:  n_state = ST_SETUP;
                        ACT_READ:                         n_state = ST_READ;
                        default:                          n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = ST_WALK;
            end
            ST_WALK: begin
                if (i_status.empty) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.walk = 1'b1;
                    if (i_status.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_READ: begin
                // hold until the result register can take the byte
                if (i_status.rd_ok) begin
                    o_cmd.rd = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/pfsb_chk.sv @@
// ----------------------------------------------------------------------------
// pfsb_chk
// Port-level checks for the frame store blitter, bound to the top level.
// ----------------------------------------------------------------------------
module pfsb_chk import pfsb_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [2:0] i_action,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_read_data
);

    // a result beat under stall stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result beat dropped while stalled");

    // and keeps its byte
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_read_data))
        else $error("result byte changed while stalled");

    // clearing pass after reset holds off input beats
    a_reset_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) == 1'b0 |-> o_stall)
        else $error("input taken during clearing pass");

    // a clear beat holds off input beats as the sweep starts
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_action == ACT_CLEAR) |=> o_stall ##1 o_stall)
        else $error("clear finished too early");

    // a result appears only after the block has issued a store read
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall, 2))
        else $error("result beat without a read in progress");

endmodule

bind page_framebuffer_sprite_blitter pfsb_chk u_chk (.*);

@@ sim/tb_page_framebuffer_sprite_blitter.sv @@
// ----------------------------------------------------------------------------
// tb_page_framebuffer_sprite_blitter
// Self-checking bench for the page-mode frame store blitter. A shadow copy of
// the store is drawn in step with every accepted action. Each read beat on the
// output channel is compared with the byte the shadow store held when the read
// was accepted, or with the byte a directed row gives. A short directed table
// comes first, then random actions with random gaps on both channels save in a quiet run.
// ----------------------------------------------------------------------------
module tb_page_framebuffer_sprite_blitter;
    import pfsb_pkg::*;

    localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;
    localparam logic [1:0] BLIT_UNUSED     = 2'd3;
    localparam int         RANDOM_ACTIONS  = 1550;
    localparam int         QUIET_FIRST     = 700;
    localparam int         QUIET_LAST      = 1000;
    localparam int         DRAIN_EVERY     = 250;
    localparam int         TAIL_CYCLES     = 1100;
    localparam int         MAX_PRINTS      = 40;

    typedef struct {
        logic [2:0]            act;
        logic signed [8:0]     x;
        logic signed [8:0]     y;
        logic                  on;
        logic [7:0]            w;
        logic [6:0]            h;
        logic [ROW_BITS_W-1:0] bits;
        logic [4:0]            ri;
        logic [1:0]            mode;
        logic [9:0]            addr;
        bit                    chk;
        logic [7:0]            want;
    } t_beat;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [2:0]            i_action = '0;
    logic signed [8:0]     i_x_pos = '0;
    logic signed [8:0]     i_y_pos = '0;
    logic                  i_pixel_on = 1'b0;
    logic [7:0]            i_rect_width = '0;
    logic [6:0]            i_rect_height = '0;
    logic [ROW_BITS_W-1:0] i_row_bits = '0;
    logic [4:0]            i_row_index = '0;
    logic [1:0]            i_blit_mode = '0;
    logic [9:0]            i_read_address = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [7:0]            o_read_data;

    logic [7:0] shadow_fb [STORE_BYTES];
    logic [7:0] pending_bytes [$];

    int send_idle_pct  = 34;
    int recv_stall_pct = 34;
    int n_fail    = 0;
    int n_checked = 0;
    int n_clear   = 0;
    int n_pixel   = 0;
    int n_rect    = 0;
    int n_sprite  = 0;
    int n_read    = 0;
    int n_ignored = 0;

    page_framebuffer_sprite_blitter i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_x_pos        (i_x_pos),
        .i_y_pos        (i_y_pos),
        .i_pixel_on     (i_pixel_on),
        .i_rect_width   (i_rect_width),
        .i_rect_height  (i_rect_height),
        .i_row_bits     (i_row_bits),
        .i_row_index    (i_row_index),
        .i_blit_mode    (i_blit_mode),
        .i_read_address (i_read_address),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_read_data    (o_read_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("timeout with %0d bytes still expected", pending_bytes.size());
        $display("FAILED: results differ");
        $finish;
    end

    task automatic note_mismatch(input string what);
        if (n_fail < MAX_PRINTS)
            $display("[%0t] mismatch: %s", $realtime, what);
        n_fail++;
    endtask

    // ---- shadow store drawing ----

    function automatic void plot_dot(input int px, input int py, input bit on);
        int idx;
        if (px < 0 || px >= SCREEN_WIDTH || py < 0 || py >= SCREEN_HEIGHT)
            return;
        idx = (py / 8) * SCREEN_WIDTH + px;
        shadow_fb[idx][py % 8] = on;
    endfunction

    function automatic void fill_box(input int px, input int py, input int bw,
                                     input int bh, input bit on);
        for (int j = 0; j < bh; j++)
            for (int i = 0; i < bw; i++)
                plot_dot(px + i, py + j, on);
    endfunction

    function automatic void draw_sprite_row(input int ox, input int oy,
                                            input logic [ROW_BITS_W-1:0] bits,
                                            input int r, input logic [1:0] mode);
        for (int c = 0; c < SPRITE_SIZE; c++) begin
            if (bits[SPRITE_SIZE-1-c]) begin
                case (mode)
                    BLIT_NORMAL: plot_dot(ox + c, oy + r, 1'b1);
                    BLIT_ROT_CW: plot_dot(ox + SPRITE_SIZE - 1 - r, oy + c, 1'b1);
                    default:     fill_box(ox + 2 * c, oy + 2 * r, 2, 2, 1'b1);
                endcase
            end
        end
    endfunction

    // Update the shadow store for one accepted beat; queue the byte a read returns.
    function automatic void apply_action(input t_beat b);
        int xs;
        int ys;
        logic [7:0] got;
        xs = $signed(b.x);
        ys = $signed(b.y);
        case (b.act)
            ACT_CLEAR: begin
                foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
                n_clear++;
            end
            ACT_PIXEL: begin
                plot_dot(xs, ys, b.on);
                n_pixel++;
            end
            ACT_RECT: begin
                fill_box(xs, ys, int'(b.w), int'(b.h), b.on);
                n_rect++;
            end
            ACT_SPRITE: begin
                if (b.mode <= BLIT_SCALED && b.ri < SPRITE_SIZE) begin
                    draw_sprite_row(xs, ys, b.bits, int'(b.ri), b.mode);
                    n_sprite++;
                end else begin
                    n_ignored++;
                end
            end
            ACT_READ: begin
                got = (b.addr < STORE_BYTES) ? shadow_fb[b.addr] : 8'h00;
                pending_bytes.push_back(b.chk ? b.want : got);
                n_read++;
            end
            default: n_ignored++;
        endcase
    endfunction

    // ---- stimulus ----

    function automatic t_beat mk(input logic [2:0] act, input int x, input int y,
                                 input bit on, input int w, input int h,
                                 input int bits, input int ri, input logic [1:0] mode,
                                 input int addr, input bit chk, input int want);
        t_beat b;
        b.act  = act;
        b.x    = 9'(x);
        b.y    = 9'(y);
        b.on   = on;
        b.w    = 8'(w);
        b.h    = 7'(h);
        b.bits = ROW_BITS_W'(bits);
        b.ri   = 5'(ri);
        b.mode = mode;
        b.addr = 10'(addr);
        b.chk  = chk;
        b.want = 8'(want);
        return b;
    endfunction

    function automatic t_beat random_beat();
        t_beat b;
        int pick;
        b.act  = 3'($urandom);
        b.x    = 9'($urandom);
        b.y    = 9'($urandom);
        b.on   = 1'($urandom);
        b.w    = 8'($urandom);
        b.h    = 7'($urandom);
        b.bits = ROW_BITS_W'($urandom);
        b.ri   = 5'($urandom);
        b.mode = 2'($urandom);
        b.addr = 10'($urandom);
        b.chk  = 1'b0;
        b.want = 8'h00;
        pick = $urandom_range(999);
        if (pick < 10) begin
            b.act = ACT_CLEAR;
        end else if (pick < 210) begin
            b.act = ACT_PIXEL;
            if ($urandom_range(9) < 8) begin
                b.x = 9'($urandom_range(SCREEN_WIDTH - 1));
                b.y = 9'($urandom_range(SCREEN_HEIGHT - 1));
            end
        end else if (pick < 360) begin
            // keep most boxes small and near the screen; the rest are full range
            b.act = ACT_RECT;
            if ($urandom_range(9) < 8) begin
                b.x = 9'($urandom_range(SCREEN_WIDTH + 7) - 8);
                b.y = 9'($urandom_range(SCREEN_HEIGHT + 7) - 8);
                b.w = 8'($urandom_range(24));
                b.h = 7'($urandom_range(16));
            end
        end else if (pick < 620) begin
            b.act  = ACT_SPRITE;
            b.mode = ($urandom_range(19) == 0) ? BLIT_UNUSED : 2'($urandom_range(2));
            b.ri   = ($urandom_range(19) == 0) ? 5'($urandom_range(31, SPRITE_SIZE))
                                              : 5'($urandom_range(SPRITE_SIZE - 1));
            if ($urandom_range(9) < 8) begin
                b.x = 9'($urandom_range(SCREEN_WIDTH + 23) - 24);
                b.y = 9'($urandom_range(SCREEN_HEIGHT + 23) - 24);
            end
        end else if (pick < 970) begin
            b.act = ACT_READ;
        end else begin
            b.act = 3'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST));
        end
        return b;
    endfunction

    // Called just after the clock rises; returns once the beat has been accepted.
    task automatic push_beat(input t_beat b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_action       <= b.act;
        i_x_pos        <= b.x;
        i_y_pos        <= b.y;
        i_pixel_on     <= b.on;
        i_rect_width   <= b.w;
        i_rect_height  <= b.h;
        i_row_bits     <= b.bits;
        i_row_index    <= b.ri;
        i_blit_mode    <= b.mode;
        i_read_address <= b.addr;
        i_valid        <= 1'b1;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        apply_action(b);
    endtask

    task automatic hold_until_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_bytes.size() != 0) @(posedge i_clk);
    endtask

    // ---- result checking ----

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid !== 1'b0 && o_valid !== 1'b1)
            note_mismatch("o_valid unknown");
        if (o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_bytes.size() == 0) begin
                note_mismatch($sformatf("unexpected read beat 0x%02h", o_read_data));
            end else begin
                if (o_read_data !== pending_bytes[0])
                    note_mismatch($sformatf("read_data 0x%02h, expected 0x%02h",
                                            o_read_data, pending_bytes[0]));
                void'(pending_bytes.pop_front());
                n_checked++;
            end
        end
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial begin
        t_beat dir_rows [$];
        t_beat b;
        int    counted;
        int    guard;

        foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;

        //                 act          x     y   on   w    h   bits       ri mode         addr chk want
        dir_rows.push_back(mk(ACT_READ,    0,    0, 0,   0,   0, 0,         0, BLIT_NORMAL,    0, 1, 8'h00));
        dir_rows.push_back(mk(ACT_READ,    0,    0, 0,   0,   0, 0,         0, BLIT_NORMAL, 1023, 1, 8'h00));
        dir_rows.push_back(mk(ACT_PIXEL,   0,    0, 1,   0,   0, 0,         0, BLIT_NORMAL,    0, 0, 0));
        dir_rows.push_back(mk(ACT_READ,    0,    0, 0,   0,   0, 0,         0, BLIT_NORMAL,    0, 1, 8'h01));
        dir_rows.push_back(mk(ACT_PIXEL, 127,   63, 1,   0,   0, 0,         0, BLIT_NORMAL,    0, 0, 0));
        dir_rows.push_back(mk(ACT_READ,    0,    0, 0,   0,   0, 0,         0, BLIT_NORMAL, 1023, 1, 8'h80));
        dir_rows.push_back(mk(ACT_PIXEL,   0,    0, 0,   0,   0, 0,         0, BLIT_NORMAL,    0, 0, 0));
        dir_rows.push_back(mk(ACT_READ,    0,    0, 0,   0,   0, 0,         0, BLIT_NORMAL,    0, 1, 8'h00));
        // off-screen dots are dropped
        dir_rows.push_back(mk(ACT_PIXEL, -256, -256, 1,  0,   0, 0,         0, BLIT_NORMAL,    0, 0, 0));
        dir_rows.push_back(mk(ACT_PIXEL, 255,  255, 1,   0,   0, 0,         0, BLIT_NORMAL,    0, 0, 0));
        dir_rows.push_back(mk(ACT_RECT,    0,    0, 1, 128,  64, 0,         0, BLIT_NORMAL,    0, 0, 0));
        dir_rows.push_back(mk(ACT_READ,    0,    0, 0,   0,   0, 0,         0, BLIT_NORMAL,  517, 1, 8'hFF));
        // empty and fully off-screen boxes draw nothing
        dir_rows.push_back(mk(ACT_RECT,    5,    5, 0,   0,  64, 0,         0, BLIT_NORMAL,    0, 0, 0));
        dir_rows.push_back(mk(ACT_RECT,    5,    5, 0, 128,   0, 0,         0, BLIT_NORMAL,    0, 0, 0));
        dir_rows.push_back(mk(ACT_RECT, -256, -256, 0, 255, 127, 0,         0, BLIT_NORMAL,    0, 0, 0));
        dir_rows.push_back(mk(ACT_READ,    0,    0, 0,   0,   0, 0,         0, BLIT_NORMAL,  133, 1, 8'hFF));
        dir_rows.push_back(mk(ACT_CLEAR,   0,    0, 0,   0,   0, 0,         0, BLIT_NORMAL,    0, 0, 0));
        dir_rows.push_back(mk(ACT_READ,    0,    0, 0,   0,   0, 0,         0, BLIT_NORMAL,  300, 1, 8'h00));
        dir_rows.push_back(mk(ACT_SPRITE,  0,    0, 0,   0,   0, 'hFFFFFF,  0, BLIT_NORMAL,    0, 0, 0));
        dir_rows.push_back(mk(ACT_READ,    0,    0, 0,   0,   0, 0,         0, BLIT_NORMAL,   23, 1, 8'h01));
        dir_rows.push_back(mk(ACT_SPRITE, 10,    8, 0,   0,   0, 'h800001,  5, BLIT_ROT_CW,    0, 0, 0));
        dir_rows.push_back(mk(ACT_READ,    0,    0, 0,   0,   0, 0,         0, BLIT_NORMAL,  156, 0, 0));
        dir_rows.push_back(mk(ACT_SPRITE, 100,  10, 0,   0,   0, 'hFFFFFF, 23, BLIT_SCALED,    0, 0, 0));
        dir_rows.push_back(mk(ACT_READ,    0,    0, 0,   0,   0, 0,         0, BLIT_NORMAL, 1006, 0, 0));
        // ignored: unused blit mode, row past the sprite, spare action code
        dir_rows.push_back(mk(ACT_SPRITE, 24,    0, 0,   0,   0, 'hFFFFFF,  0, BLIT_UNUSED,    0, 0, 0));
        dir_rows.push_back(mk(ACT_SPRITE, 24,    0, 0,   0,   0, 'hFFFFFF, 31, BLIT_NORMAL,    0, 0, 0));
        dir_rows.push_back(mk(ACT_SPARE_LAST, 0, 0, 1, 128, 64, 'hFFFFFF,  0, BLIT_NORMAL,    0, 0, 0));
        dir_rows.push_back(mk(ACT_READ,    0,    0, 0,   0,   0, 0,         0, BLIT_NORMAL,   24, 1, 8'h00));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) push_beat(dir_rows[i]);

        counted = 0;
        while (counted < RANDOM_ACTIONS) begin
            if (counted >= QUIET_FIRST && counted < QUIET_LAST) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end else begin
                send_idle_pct  = 34;
                recv_stall_pct = 34;
            end
            b = random_beat();
            push_beat(b);
            counted++;
            if (counted % DRAIN_EVERY == 0) hold_until_drained();
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        guard = 0;
        while (pending_bytes.size() != 0 && guard < 200_000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        foreach (pending_bytes[i])
            note_mismatch($sformatf("expected byte 0x%02h never arrived", pending_bytes[i]));

        $display("Covered %0d clears, %0d pixels, %0d boxes, %0d sprite rows, %0d ignored",
                 n_clear, n_pixel, n_rect, n_sprite, n_ignored);
        $display("Compared %0d of %0d store reads, %0d mismatches", n_checked, n_read, n_fail);
        if (n_fail == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/pfsb_pkg.sv
hw/rtl/pfsb_ram.sv
hw/rtl/pfsb_dp.sv
hw/rtl/pfsb_ctrl.sv
hw/rtl/page_framebuffer_sprite_blitter.sv
hw/rtl/pfsb_chk.sv
sim/tb_page_framebuffer_sprite_blitter.sv
